FILE: sv/wfm_pkg.sv
// ----------------------------------------------------------------------------
// wfm_pkg
// Shared types, bus addresses and widths of the wavetable channel.
// ----------------------------------------------------------------------------
package wfm_pkg;

    localparam int WAVE_DEPTH_DEF = 64;
    localparam int MOD_DEPTH_DEF  = 64;

    localparam int KIND_W    = 2;
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int WAVE_W    = 6;
    localparam int MODV_W    = 3;
    localparam int VOL_W     = 6;
    localparam int SMP_W     = 12;
    localparam int STEP_W    = 12;
    localparam int SWEEP_W   = 4;
    localparam int GAIN_W    = 8;
    localparam int PHASE_W   = 18;
    localparam int PHASE_FRAC = 12;
    localparam int SCNT_W    = 3;
    localparam int MOD_SHIFT = 3;
    localparam int SAT_W     = 10;

    localparam logic [VOL_W-1:0]  VOL_MAX     = '1;
    localparam logic [DATA_W-1:0] WAVE_CENTER = 8'd32;
    localparam logic signed [SAT_W-1:0] GAIN_MIN = -10'sd128;
    localparam logic signed [SAT_W-1:0] GAIN_MAX = 10'sd127;

    localparam logic [ADDR_W-1:0] ADDR_WAVE_LO  = 16'h4040;
    localparam logic [ADDR_W-1:0] ADDR_WAVE_HI  = 16'h407F;
    localparam logic [ADDR_W-1:0] ADDR_ENV      = 16'h4080;
    localparam logic [ADDR_W-1:0] ADDR_CAR_HI   = 16'h4081;
    localparam logic [ADDR_W-1:0] ADDR_CAR_LO   = 16'h4082;
    localparam logic [ADDR_W-1:0] ADDR_MODF_HI  = 16'h4083;
    localparam logic [ADDR_W-1:0] ADDR_SWP_DN   = 16'h4084;
    localparam logic [ADDR_W-1:0] ADDR_SWP_UP   = 16'h4085;
    localparam logic [ADDR_W-1:0] ADDR_GAIN_DN  = 16'h4086;
    localparam logic [ADDR_W-1:0] ADDR_GAIN_UP  = 16'h4087;
    localparam logic [ADDR_W-1:0] ADDR_MOD_TBL  = 16'h4088;
    localparam logic [ADDR_W-1:0] ADDR_MOD_DIS  = 16'h408A;
    localparam logic [ADDR_W-1:0] ADDR_VOL_RD   = 16'h4090;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_SAMPLE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SAT,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [PHASE_W-1:0]   a;
        logic [PHASE_W-1:0]   b;
    } t_alu_req;

endpackage

FILE: sv/wfm_in_if.sv
// ----------------------------------------------------------------------------
// wfm_in_if
// Request channel: word kind, bus address and write byte.
// ----------------------------------------------------------------------------
interface wfm_in_if import wfm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;

    modport source (output valid, kind, addr, wdata, input ready);
    modport sink   (input valid, kind, addr, wdata, output ready);
endinterface

FILE: sv/wfm_out_if.sv
// ----------------------------------------------------------------------------
// wfm_out_if
// Result channel: bus read data and signed sample.
// ----------------------------------------------------------------------------
interface wfm_out_if import wfm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [VOL_W-1:0]         read_data;
    logic signed [SMP_W-1:0]  sample_value;

    modport source (output valid, read_data, sample_value, input ready);
    modport sink   (input valid, read_data, sample_value, output ready);
endinterface

FILE: sv/wfm_alu.sv
// ----------------------------------------------------------------------------
// wfm_alu
// Shared arithmetic unit: phase add, saturating gain add, 8x8 signed multiply.
// ----------------------------------------------------------------------------
module wfm_alu import wfm_pkg::*; (
    input  t_alu_req            i_req,
    output logic [PHASE_W-1:0]  o_y
);

    logic signed [SAT_W-1:0]      sat_sum;
    logic signed [2*GAIN_W-1:0]   prod;
    logic [GAIN_W-1:0]            sat_res;

    always_comb begin
        sat_sum = $signed(i_req.a[SAT_W-1:0]) + $signed(i_req.b[SAT_W-1:0]);
        prod    = $signed(i_req.a[GAIN_W-1:0]) * $signed(i_req.b[GAIN_W-1:0]);
        if (sat_sum < GAIN_MIN) begin
            sat_res = GAIN_MIN[GAIN_W-1:0];
        end else if (sat_sum > GAIN_MAX) begin
            sat_res = GAIN_MAX[GAIN_W-1:0];
        end else begin
            sat_res = sat_sum[GAIN_W-1:0];
        end
        case (i_req.op)
            ALU_ADD: o_y = i_req.a + i_req.b;
            ALU_SAT: o_y = {{(PHASE_W-GAIN_W){sat_res[GAIN_W-1]}}, sat_res};
            ALU_MUL: o_y = {{(PHASE_W-2*GAIN_W){prod[2*GAIN_W-1]}}, prod};
            default: o_y = '0;
        endcase
    end

endmodule

FILE: sv/wfm_ram.sv
// ----------------------------------------------------------------------------
// wfm_ram
// Table RAM with one write port, one registered read port and per-entry
// valid flags so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module wfm_ram import wfm_pkg::*; #(
    parameter int DEPTH = WAVE_DEPTH_DEF,
    parameter int WIDTH = WAVE_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: sv/wavetable_fm_audio_channel_unit.sv
// ----------------------------------------------------------------------------
// wavetable_fm_audio_channel_unit
// Wavetable channel with phase modulation, run by a small sequencer around
// one shared arithmetic unit and two table RAMs.
//
//   channel  dir  payload                           handshake
//   i_in     in   kind, addr, wdata                 valid / ready
//   o_out    out  read_data, sample_value           valid / ready
//
// Steps per word: write decode; read decode, done; tick decode, modulator
// add, on a sweep step sweep down and up, envelope; sample decode, multiply,
// wave read, multiply, done, or decode, done with a zero carrier step.
// Reset clears state and RAM valid flags, not input, offset or output data.
// A result is held in the output register; a read or sample waits in its
// last step while the previous result is still not taken.
// ----------------------------------------------------------------------------
module wavetable_fm_audio_channel_unit import wfm_pkg::*; #(
    parameter int WAVE_DEPTH = WAVE_DEPTH_DEF,
    parameter int MOD_DEPTH  = MOD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wfm_in_if.sink      i_in,
    wfm_out_if.source   o_out
);

    localparam int WAW = $clog2(WAVE_DEPTH);
    localparam int MAW = $clog2(MOD_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_MOD,
        S_TICK_DOWN,
        S_TICK_UP,
        S_TICK_ENV,
        S_SMP_MUL1,
        S_SMP_WRD,
        S_SMP_MUL2,
        S_DONE
    } t_state;

    t_state              r_state;
    t_kind               r_kind;
    logic [ADDR_W-1:0]   r_addr;
    logic [DATA_W-1:0]   r_wdata;

    logic [WAW-1:0]      r_wave_ptr;
    logic [MAW-1:0]      r_mod_ptr;
    logic                r_env_off;
    logic                r_env_up;
    logic [VOL_W-1:0]    r_vol;
    logic [STEP_W-1:0]   r_car_step;
    logic [STEP_W-1:0]   r_mod_step;
    logic                r_mod_off;
    logic [SWEEP_W-1:0]  r_swp_dn;
    logic [SWEEP_W-1:0]  r_swp_up;
    logic [GAIN_W-1:0]   r_gain;
    logic [PHASE_W-1:0]  r_car_phase;
    logic [PHASE_W-1:0]  r_mod_phase;
    logic [SCNT_W-1:0]   r_sweep;
    logic [WAW-1:0]      r_off;

    logic [VOL_W-1:0]    r_res_rd;
    logic [SMP_W-1:0]    r_res_smp;
    logic                r_out_valid;
    logic [VOL_W-1:0]    r_out_rd;
    logic [SMP_W-1:0]    r_out_smp;

    t_alu_req            alu_req;
    logic [PHASE_W-1:0]  alu_y;
    logic                wave_we;
    logic                mod_we;
    logic                wave_hit;
    logic [WAW-1:0]      wave_rd_addr;
    logic [WAVE_W-1:0]   wave_rd_data;
    logic [MODV_W-1:0]   mod_rd_data;
    logic [SCNT_W-1:0]   sweep_nx;
    logic                accept;
    logic                out_load;
    logic [GAIN_W-1:0]   wave_off;

    assign accept   = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign sweep_nx = r_sweep + SCNT_W'(1);
    assign wave_hit = (r_addr >= ADDR_WAVE_LO) && (r_addr <= ADDR_WAVE_HI);
    assign wave_we  = (r_state == S_DECODE) && (r_kind == KIND_WRITE) && wave_hit;
    assign mod_we   = (r_state == S_DECODE) && (r_kind == KIND_WRITE)
                      && (r_addr == ADDR_MOD_TBL);
    assign wave_rd_addr = r_car_phase[PHASE_FRAC +: WAW] + r_off;
    assign wave_off = {2'b00, wave_rd_data} - WAVE_CENTER;

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_out_rd;
    assign o_out.sample_value = r_out_smp;

    always_comb begin
        alu_req.op = ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (r_state)
            S_DECODE: begin
                if (r_kind == KIND_TICK) begin
                    alu_req.a = r_car_phase;
                    alu_req.b = PHASE_W'(r_car_step);
                end else if (r_kind == KIND_WRITE) begin
                    alu_req.op = ALU_SAT;
                    alu_req.a  = {{(PHASE_W-GAIN_W){r_gain[GAIN_W-1]}}, r_gain};
                    if (r_addr == ADDR_GAIN_DN) begin
                        alu_req.b = PHASE_W'(0) - PHASE_W'(r_wdata[VOL_W-1:0]);
                    end else begin
                        alu_req.b = PHASE_W'(r_wdata[VOL_W-1:0]);
                    end
                end
            end
            S_TICK_MOD: begin
                alu_req.a = r_mod_phase;
                alu_req.b = PHASE_W'(r_mod_step);
            end
            S_TICK_DOWN: begin
                alu_req.op = ALU_SAT;
                alu_req.a  = {{(PHASE_W-GAIN_W){r_gain[GAIN_W-1]}}, r_gain};
                alu_req.b  = PHASE_W'(0) - PHASE_W'(r_swp_dn);
            end
            S_TICK_UP: begin
                alu_req.op = ALU_SAT;
                alu_req.a  = {{(PHASE_W-GAIN_W){r_gain[GAIN_W-1]}}, r_gain};
                alu_req.b  = PHASE_W'(r_swp_up);
            end
            S_SMP_MUL1: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = PHASE_W'(r_gain);
                alu_req.b  = PHASE_W'(mod_rd_data);
            end
            S_SMP_MUL2: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = PHASE_W'(wave_off);
                alu_req.b  = PHASE_W'(r_vol);
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    wfm_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    wfm_ram #(
        .DEPTH (WAVE_DEPTH),
        .WIDTH (WAVE_W)
    ) u_wave_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wave_we),
        .i_wr_addr (r_wave_ptr),
        .i_wr_data (r_wdata[WAVE_W-1:0]),
        .i_rd_addr (wave_rd_addr),
        .o_rd_data (wave_rd_data)
    );

    wfm_ram #(
        .DEPTH (MOD_DEPTH),
        .WIDTH (MODV_W)
    ) u_mod_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mod_we),
        .i_wr_addr (r_mod_ptr),
        .i_wr_data (r_wdata[MODV_W-1:0]),
        .i_rd_addr (r_mod_phase[PHASE_FRAC +: MAW]),
        .o_rd_data (mod_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= t_kind'(i_in.kind);
            r_addr  <= i_in.addr;
            r_wdata <= i_in.wdata;
        end
        if (out_load) begin
            r_out_rd  <= r_res_rd;
            r_out_smp <= r_res_smp;
        end
        if (r_state == S_SMP_MUL1) begin
            r_off <= r_mod_off ? '0 : alu_y[MOD_SHIFT +: WAW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wave_ptr  <= '0;
            r_mod_ptr   <= '0;
            r_env_off   <= 1'b0;
            r_env_up    <= 1'b0;
            r_vol       <= '0;
            r_car_step  <= '0;
            r_mod_step  <= '0;
            r_mod_off   <= 1'b1;
            r_swp_dn    <= '0;
            r_swp_up    <= '0;
            r_gain      <= '0;
            r_car_phase <= '0;
            r_mod_phase <= '0;
            r_sweep     <= '0;
            r_res_rd    <= '0;
            r_res_smp   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (r_kind)
                        KIND_WRITE: begin
                            r_state <= S_IDLE;
                            if (wave_hit) begin
                                r_wave_ptr <= r_wave_ptr + WAW'(1);
                            end
                            case (r_addr)
                                ADDR_ENV: begin
                                    r_env_off <= r_wdata[6];
                                    r_env_up  <= r_wdata[7];
                                    if (r_wdata[6]) begin
                                        r_vol <= r_wdata[VOL_W-1:0];
                                    end else begin
                                        r_vol <= r_wdata[7] ? '0 : VOL_MAX;
                                    end
                                end
                                ADDR_CAR_HI:  r_car_step[STEP_W-1:8] <= r_wdata[3:0];
                                ADDR_CAR_LO:  r_car_step[7:0] <= r_wdata;
                                ADDR_MODF_HI: begin
                                    r_mod_step[STEP_W-1:8] <= r_wdata[3:0];
                                    if (r_wdata[7]) begin
                                        r_mod_off   <= 1'b1;
                                        r_mod_phase <= '0;
                                    end
                                end
                                ADDR_SWP_DN:  r_swp_dn <= r_wdata[SWEEP_W-1:0];
                                ADDR_SWP_UP:  r_swp_up <= r_wdata[SWEEP_W-1:0];
                                ADDR_GAIN_DN: r_gain <= alu_y[GAIN_W-1:0];
                                ADDR_GAIN_UP: begin
                                    r_gain    <= alu_y[GAIN_W-1:0];
                                    r_mod_off <= r_wdata[7];
                                end
                                ADDR_MOD_TBL: r_mod_ptr <= r_mod_ptr + MAW'(1);
                                ADDR_MOD_DIS: begin
                                    if (r_wdata[7]) begin
                                        r_mod_off <= 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        KIND_READ: begin
                            r_res_rd  <= (r_addr == ADDR_VOL_RD) ? r_vol : '0;
                            r_res_smp <= '0;
                            r_state   <= S_DONE;
                        end
                        KIND_TICK: begin
                            r_car_phase <= alu_y;
                            r_state     <= S_TICK_MOD;
                        end
                        default: begin
                            r_res_rd  <= '0;
                            r_res_smp <= '0;
                            r_state   <= (r_car_step == '0) ? S_DONE : S_SMP_MUL1;
                        end
                    endcase
                end
                S_TICK_MOD: begin
                    if (!r_mod_off) begin
                        r_mod_phase <= alu_y;
                        r_sweep     <= sweep_nx;
                    end
                    if (!r_mod_off && sweep_nx == '0) begin
                        r_state <= S_TICK_DOWN;
                    end else begin
                        r_state <= S_TICK_ENV;
                    end
                end
                S_TICK_DOWN: begin
                    if (r_swp_dn != '0) begin
                        r_gain <= alu_y[GAIN_W-1:0];
                    end
                    r_state <= S_TICK_UP;
                end
                S_TICK_UP: begin
                    if (r_swp_up != '0) begin
                        r_gain <= alu_y[GAIN_W-1:0];
                    end
                    r_state <= S_TICK_ENV;
                end
                S_TICK_ENV: begin
                    if (!r_env_off && r_sweep == '0) begin
                        if (r_env_up && r_vol != VOL_MAX) begin
                            r_vol <= r_vol + VOL_W'(1);
                        end else if (!r_env_up && r_vol != '0) begin
                            r_vol <= r_vol - VOL_W'(1);
                        end
                    end
                    r_state <= S_IDLE;
                end
                S_SMP_MUL1: begin
                    r_state <= S_SMP_WRD;
                end
                S_SMP_WRD: begin
                    r_state <= S_SMP_MUL2;
                end
                S_SMP_MUL2: begin
                    r_res_smp <= alu_y[SMP_W-1:0];
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");

    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE && r_kind == KIND_SAMPLE && r_car_step == '0)
        |=> (r_res_smp == '0 && r_state == S_DONE))
        else $error("sample with zero carrier step not zero");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done step");

    a_sweep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK_MOD && r_mod_off) |=> $stable(r_sweep))
        else $error("sweep count moved while modulator off");

endmodule
